// File: rtl/dcms_pkg.sv
// Shared types, constants and the CRC-32 byte update for the dual-copy selector.
`timescale 1ns / 1ps

package dcms_pkg;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] SeqOne  = 32'd1;

  localparam int unsigned PaddrW = 3;

  // Register indexes, taken from paddr[2]
  localparam logic RegMagic = 1'b0;

  // newest_copy codes
  localparam logic [1:0] NewestCopy0 = 2'd0;
  localparam logic [1:0] NewestCopy1 = 2'd1;
  localparam logic [1:0] NewestNone  = 2'd2;

  typedef struct packed {
    logic        first_ok;
    logic [31:0] first_seq;
    logic        second_ok;
    logic [31:0] second_seq;
  } sel_in_t;

  typedef struct packed {
    logic [1:0]  newest_copy;
    logic        write_target;
    logic [31:0] next_sequence;
    logic        copy0_valid;
    logic        copy1_valid;
  } result_t;

  // Reflected CRC-32, one byte, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// File: rtl/dcms_if.sv
// Valid/ready stream interfaces for the input byte beats and the selection result beats.
`timescale 1ns / 1ps

interface dcms_in_if;
  logic        valid;
  logic        ready;
  logic        copy_index;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] magic_word;
  logic [31:0] seq_number;
  logic [31:0] stored_crc;

  modport source (output valid, copy_index, data_byte, last_byte, magic_word, seq_number,
                  stored_crc, input ready);
  modport sink (input valid, copy_index, data_byte, last_byte, magic_word, seq_number,
                stored_crc, output ready);
endinterface

interface dcms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  newest_copy;
  logic        write_target;
  logic [31:0] next_sequence;
  logic        copy0_valid;
  logic        copy1_valid;

  modport source (output valid, newest_copy, write_target, next_sequence, copy0_valid,
                  copy1_valid, input ready);
  modport sink (input valid, newest_copy, write_target, next_sequence, copy0_valid,
                copy1_valid, output ready);
endinterface

// File: rtl/dcms_select.sv
// Picks the newest valid copy, the copy to overwrite and the next sequence number.
`timescale 1ns / 1ps

module dcms_select (
  input  dcms_pkg::sel_in_t sel_i,
  output dcms_pkg::result_t res_o
);
  import dcms_pkg::*;

  logic second_newer;

  // Ties go to copy 0
  assign second_newer = sel_i.second_seq > sel_i.first_seq;

  always_comb begin
    res_o.copy0_valid = sel_i.first_ok;
    res_o.copy1_valid = sel_i.second_ok;
    case ({sel_i.first_ok, sel_i.second_ok})
      2'b11: begin
        res_o.newest_copy   = second_newer ? NewestCopy1 : NewestCopy0;
        res_o.write_target  = ~second_newer;
        res_o.next_sequence = (second_newer ? sel_i.second_seq : sel_i.first_seq) + SeqOne;
      end
      2'b10: begin
        res_o.newest_copy   = NewestCopy0;
        res_o.write_target  = 1'b1;
        res_o.next_sequence = sel_i.first_seq + SeqOne;
      end
      2'b01: begin
        res_o.newest_copy   = NewestCopy1;
        res_o.write_target  = 1'b0;
        res_o.next_sequence = sel_i.second_seq + SeqOne;
      end
      default: begin
        res_o.newest_copy   = NewestNone;
        res_o.write_target  = 1'b0;
        res_o.next_sequence = SeqOne;
      end
    endcase
  end

endmodule

// File: rtl/dual_copy_metadata_selector_core.sv
// Top level: byte-wise CRC-32 check of two metadata copies and newest-copy selection.
//
//   channel   dir  handshake          content
//   in_i      in   valid/ready        one covered byte plus copy header fields
//   out_o     out  valid/ready        one selection result per copy 1 end
//   apb       in   psel/penable       magic_value register at address 0
//
// One byte beat per cycle unless a waiting result stalls the byte that ends copy 1; the result
// is registered by the input register and the result register around the CRC byte update.
// Reset clears the CRC to all ones, the latched copy 0 state and both valid flags.
// A waiting result stalls only the byte that ends copy 1 and the input behind it; other bytes keep flowing.
`timescale 1ns / 1ps

module dual_copy_metadata_selector_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dcms_in_if.sink                         in_i,
  dcms_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dcms_pkg::PaddrW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import dcms_pkg::*;

  logic [31:0] magic_q;

  logic        s1_valid_q;
  logic        s1_copy_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic [31:0] s1_magic_q;
  logic [31:0] s1_seq_q;
  logic [31:0] s1_scrc_q;

  logic [31:0] crc_q, crc_d;
  logic        first_ok_q;
  logic [31:0] first_seq_q;

  logic        out_valid_q;
  result_t     out_q;

  logic        s1_ends_pair;
  logic        s1_adv;
  logic        copy_ok;
  sel_in_t     sel;
  result_t     sel_res;

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMagic) ? magic_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= 32'd0;
    end else if (psel && penable && pwrite && paddr[2] == RegMagic) begin
      magic_q <= pwdata;
    end
  end

  // Byte stage
  assign s1_ends_pair = s1_last_q && s1_copy_q;
  assign s1_adv       = s1_valid_q && (!s1_ends_pair || !out_valid_q || out_o.ready);
  assign in_i.ready   = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_copy_q  <= in_i.copy_index;
      s1_byte_q  <= in_i.data_byte;
      s1_last_q  <= in_i.last_byte;
      s1_magic_q <= in_i.magic_word;
      s1_seq_q   <= in_i.seq_number;
      s1_scrc_q  <= in_i.stored_crc;
    end
  end

  assign crc_d   = crc_byte(crc_q, s1_byte_q);
  assign copy_ok = (s1_magic_q == magic_q) && (s1_scrc_q == ~crc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      first_ok_q  <= 1'b0;
      first_seq_q <= 32'd0;
    end else if (s1_adv) begin
      crc_q <= s1_last_q ? CrcInit : crc_d;
      if (s1_last_q) begin
        // Latch copy 0, or clear after judging the pair
        first_ok_q  <= s1_copy_q ? 1'b0 : copy_ok;
        first_seq_q <= s1_copy_q ? 32'd0 : s1_seq_q;
      end
    end
  end

  assign sel.first_ok   = first_ok_q;
  assign sel.first_seq  = first_seq_q;
  assign sel.second_ok  = copy_ok;
  assign sel.second_seq = s1_seq_q;

  dcms_select u_select (
    .sel_i (sel),
    .res_o (sel_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_ends_pair) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_ends_pair) begin
      out_q <= sel_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.newest_copy   = out_q.newest_copy;
  assign out_o.write_target  = out_q.write_target;
  assign out_o.next_sequence = out_q.next_sequence;
  assign out_o.copy0_valid   = out_q.copy0_valid;
  assign out_o.copy1_valid   = out_q.copy1_valid;

  // Checks
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (crc_q == CrcInit))
    else $error("CRC not restarted after last byte");

  a_pair_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_ends_pair) |=> (!first_ok_q && first_seq_q == 32'd0))
    else $error("copy 0 state not cleared after pair");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_ends_pair))
    else $error("result beat without end of copy 1");

  a_none_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.newest_copy == NewestNone) |->
      (!out_q.copy0_valid && !out_q.copy1_valid && out_q.next_sequence == SeqOne
       && !out_q.write_target))
    else $error("inconsistent result with no valid copy");

  a_target_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.newest_copy != NewestNone) |->
      (out_q.write_target != out_q.newest_copy[0]))
    else $error("write target equals newest copy");

endmodule

// File: verif/testbench.sv
// Testbench for the dual-copy selector: CRC-checked copy pairs, random stalls, result checks.
`timescale 1ns / 1ps

module testbench;
  import dcms_pkg::*;

  typedef struct {
    logic        copy_index;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] magic_word;
    logic [31:0] seq_number;
    logic [31:0] stored_crc;
  } byte_beat_t;

  logic        clk;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dcms_in_if  in_bus ();
  dcms_out_if out_bus ();

  dual_copy_metadata_selector_core i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  byte_beat_t  byte_queue[$];
  result_t     selection_queue[$];
  byte_beat_t  on_bus;
  int          mismatches = 0;
  bit          steady = 1'b0;

  // Predictor state
  logic [31:0] magic_reg = 32'd0;
  logic [31:0] crc_acc = CrcInit;
  logic        held_ok = 1'b0;
  logic [31:0] held_seq = 32'd0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Fold one accepted byte beat; on the end of copy 1 queue the expected selection.
  task automatic absorb_byte(input byte_beat_t b);
    logic [31:0] final_crc;
    logic        ok;
    result_t     sel;
    crc_acc = crc32_update(crc_acc, b.data_byte);
    if (b.last_byte) begin
      final_crc = ~crc_acc;
      crc_acc = CrcInit;
      ok = (b.magic_word == magic_reg) && (b.stored_crc == final_crc);
      if (!b.copy_index) begin
        held_ok = ok;
        held_seq = b.seq_number;
      end else begin
        sel.copy0_valid = held_ok;
        sel.copy1_valid = ok;
        if (held_ok && ok) begin
          sel.newest_copy = (b.seq_number > held_seq) ? NewestCopy1 : NewestCopy0;
        end else if (held_ok) begin
          sel.newest_copy = NewestCopy0;
        end else if (ok) begin
          sel.newest_copy = NewestCopy1;
        end else begin
          sel.newest_copy = NewestNone;
        end
        case (sel.newest_copy)
          NewestCopy0: begin
            sel.write_target = 1'b1;
            sel.next_sequence = held_seq + SeqOne;
          end
          NewestCopy1: begin
            sel.write_target = 1'b0;
            sel.next_sequence = b.seq_number + SeqOne;
          end
          default: begin
            sel.write_target = 1'b0;
            sel.next_sequence = SeqOne;
          end
        endcase
        selection_queue.push_back(sel);
        held_ok = 1'b0;
        held_seq = 32'd0;
      end
    end
  endtask

  // Driver: hold valid until accepted, then pull the next beat or idle
  always @(posedge clk) begin
    logic take_next;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      take_next = !in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        absorb_byte(on_bus);
        take_next = 1'b1;
      end
      if (take_next) begin
        if (byte_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 36)) begin
          on_bus = byte_queue.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.copy_index <= on_bus.copy_index;
          in_bus.data_byte  <= on_bus.data_byte;
          in_bus.last_byte  <= on_bus.last_byte;
          in_bus.magic_word <= on_bus.magic_word;
          in_bus.seq_number <= on_bus.seq_number;
          in_bus.stored_crc <= on_bus.stored_crc;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: random backpressure, check each accepted result beat
  always @(posedge clk) begin
    result_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (selection_queue.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual newest %0d next %0h",
                   $time, out_bus.newest_copy, out_bus.next_sequence);
          mismatches++;
        end else begin
          want = selection_queue.pop_front();
          compare_field("newest_copy", 32'(want.newest_copy), 32'(out_bus.newest_copy));
          compare_field("write_target", 32'(want.write_target), 32'(out_bus.write_target));
          compare_field("next_sequence", want.next_sequence, out_bus.next_sequence);
          compare_field("copy0_valid", 32'(want.copy0_valid), 32'(out_bus.copy0_valid));
          compare_field("copy1_valid", 32'(want.copy1_valid), 32'(out_bus.copy1_valid));
        end
      end
      out_bus.ready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  task automatic write_magic(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegMagic, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    magic_reg = value;
  endtask

  // Queue one copy; fill < 0 gives random bytes. Non-final beats carry random header noise.
  task automatic queue_copy(input logic copy, input int nbytes, input logic [31:0] magic,
                            input logic [31:0] seq, input bit crc_ok, input int fill);
    logic [31:0] crc;
    byte_beat_t  b;
    crc = CrcInit;
    for (int k = 0; k < nbytes; k++) begin
      b.copy_index = 1'($urandom);
      b.data_byte  = (fill < 0) ? 8'($urandom) : fill[7:0];
      b.last_byte  = (k == nbytes - 1);
      b.magic_word = $urandom;
      b.seq_number = $urandom;
      b.stored_crc = $urandom;
      crc = crc32_update(crc, b.data_byte);
      if (b.last_byte) begin
        b.copy_index = copy;
        b.magic_word = magic;
        b.seq_number = seq;
        b.stored_crc = crc_ok ? ~crc : (~crc ^ (32'd1 << $urandom_range(0, 31)));
      end
      byte_queue.push_back(b);
    end
  endtask

  // Wait until no beat is pending and no result is outstanding, then let the pipe settle
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (byte_queue.size() != 0 || in_bus.valid || selection_queue.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_magic();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1, 2: return magic_reg ^ (32'd1 << $urandom_range(0, 31));
      default: return magic_reg;
    endcase
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 32) : $urandom_range(1, 6);
  endfunction

  task automatic queue_random_phase(input int nbytes);
    int          made;
    int          len0;
    int          len1;
    int          roll;
    logic [31:0] s0;
    logic [31:0] s1;
    made = 0;
    while (made < nbytes) begin
      roll = $urandom_range(0, 99);
      len0 = pick_len();
      len1 = pick_len();
      s0 = pick_seq();
      // keep the pair sequences close half of the time so the comparison matters
      s1 = ($urandom_range(0, 1) == 0) ? s0 + $urandom_range(0, 4) - 2 : pick_seq();
      if (roll < 80) begin
        queue_copy(1'b0, len0, pick_magic(), s0, $urandom_range(0, 4) != 0, -1);
        queue_copy(1'b1, len1, pick_magic(), s1, $urandom_range(0, 4) != 0, -1);
        made += len0 + len1;
      end else if (roll < 90) begin
        queue_copy(1'b1, len1, pick_magic(), s1, $urandom_range(0, 3) != 0, -1);
        made += len1;
      end else begin
        queue_copy(1'b0, len0, pick_magic(), s0, $urandom_range(0, 3) != 0, -1);
        made += len0;
      end
    end
  endtask

  initial begin
    logic [31:0] m;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.copy_index = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.last_byte  = 1'b0;
    in_bus.magic_word = '0;
    in_bus.seq_number = '0;
    in_bus.stored_crc = '0;
    out_bus.ready     = 1'b0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;

    // Reset value of the magic register is zero
    queue_copy(1'b0, 1, 32'd0, 32'd41, 1'b1, 8'h00);
    queue_copy(1'b1, 1, 32'd0, 32'd77, 1'b0, 8'hFF);
    wait_idle();

    write_magic(32'hA5C3_0F1E);
    m = magic_reg;
    queue_copy(1'b0, 1, m, 32'd5, 1'b1, 8'h00);
    queue_copy(1'b1, 1, m, 32'd6, 1'b1, 8'hFF);
    // equal sequences: copy 0 wins
    queue_copy(1'b0, 2, m, 32'd9, 1'b1, -1);
    queue_copy(1'b1, 1, m, 32'd9, 1'b1, -1);
    // wrapped sequence reads as older, next sequence wraps to zero
    queue_copy(1'b0, 1, m, 32'hFFFF_FFFF, 1'b1, -1);
    queue_copy(1'b1, 1, m, 32'd0, 1'b1, -1);
    // copy 1 with no copy 0 ahead of it
    queue_copy(1'b1, 2, m, 32'd3, 1'b1, -1);
    // repeated copy 0: the later, broken one replaces the good one
    queue_copy(1'b0, 1, m, 32'd100, 1'b1, -1);
    queue_copy(1'b0, 2, m, 32'd200, 1'b0, -1);
    queue_copy(1'b1, 1, ~m, 32'd300, 1'b1, -1);
    // wrong magic with good CRC, then good magic with bad CRC
    queue_copy(1'b0, 1, m ^ 32'h8000_0000, 32'd12, 1'b1, -1);
    queue_copy(1'b1, 1, m, 32'd13, 1'b0, -1);
    queue_copy(1'b0, 1, m, 32'd0, 1'b1, -1);
    queue_copy(1'b1, 1, m, 32'd8, 1'b0, -1);
    wait_idle();

    write_magic(32'hFFFF_FFFF);
    queue_random_phase(100);
    wait_idle();

    write_magic($urandom);
    steady = 1'b1;
    queue_random_phase(100);
    wait_idle();
    steady = 1'b0;

    write_magic(32'd0);
    queue_random_phase(100);
    wait_idle();

    write_magic($urandom);
    queue_random_phase(100);
    wait_idle();
    repeat (6) @(posedge clk);

    if (mismatches == 0 && selection_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", selection_queue.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
rtl/dcms_pkg.sv
rtl/dcms_if.sv
rtl/dcms_select.sv
rtl/dual_copy_metadata_selector_core.sv
verif/testbench.sv
